// File: hw/rtl/mmt_pkg.sv
// Shared types and constants for the 4x4 fixed-point matrix unit.
package mmt_pkg;

  // Request kind codes as they arrive on the request channel.
  localparam logic [2:0] KIND_LOAD_LEFT       = 3'd0;
  localparam logic [2:0] KIND_LOAD_RIGHT      = 3'd1;
  localparam logic [2:0] KIND_MULTIPLY        = 3'd2;
  localparam logic [2:0] KIND_MULTIPLY_UPDATE = 3'd3;
  localparam logic [2:0] KIND_TRANSPOSE       = 3'd4;

  // Saturation limits of a signed Q16.16 word.
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Operation carried from the front to the back.
  typedef enum logic [2:0] {
    OP_LOAD_LEFT,
    OP_LOAD_RIGHT,
    OP_MULTIPLY,
    OP_MULTIPLY_UPDATE,
    OP_TRANSPOSE
  } op_t;

  // One classified command.
  typedef struct packed {
    op_t         op;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
  } cmd_t;

endpackage

// File: hw/rtl/mmt_in_if.sv
// Request channel: one load or command request with a valid/ready handshake.
interface mmt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  row;
  logic [1:0]  col;
  logic [31:0] value;

  modport source (output valid, output kind, output row, output col, output value,
                  input ready);
  modport sink (input valid, input kind, input row, input col, input value,
                output ready);
endinterface

// File: hw/rtl/mmt_out_if.sv
// Result channel: one emitted matrix element with a valid/ready handshake.
interface mmt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_row;
  logic [1:0]  out_col;
  logic [31:0] out_value;
  logic        saturated;
  logic        last;

  modport source (output valid, output out_row, output out_col, output out_value,
                  output saturated, output last, input ready);
  modport sink (input valid, input out_row, input out_col, input out_value,
                input saturated, input last, output ready);
endinterface

// File: hw/rtl/matrix4_multiply_transpose.sv
// Top level of the fixed-point matrix unit: front end, command queue and engine.
// The unit holds a left and a right DIM x DIM matrix of signed Q16.16 words, zero
// after reset. A load request writes one element.
// A multiply, multiply-and-update or transpose request streams DIM*DIM result
// elements in row-major order, at most one per cycle, through a four-stage pipeline
// (storage read, DIM parallel 32x32 multipliers, exact sum, scale and clip); the
// engine then waits until the stages ahead of the result register are empty
// before it takes the next request. The update variant writes each product row
// back to the left matrix after the row is complete, so every product uses the
// old left matrix. Requests are taken while results are still streaming, up to
// the depth of the queue plus the front register.
module matrix4_multiply_transpose #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  mmt_in_if.sink   cmd,
  mmt_out_if.source result
);

  logic          f_valid;
  logic          f_ready;
  mmt_pkg::cmd_t f_cmd;
  logic          q_valid;
  logic          q_ready;
  mmt_pkg::cmd_t q_cmd;

  // Accept and classify requests.
  mmt_front #(
    .DIM (DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (cmd),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // Decouple the front from the engine.
  mmt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  // Execute commands and emit results.
  mmt_back #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .res       (result)
  );

endmodule

// File: hw/rtl/mmt_front.sv
// Front end: accepts requests, drops meaningless ones and registers the command.
module mmt_front #(
  parameter int DIM = 4
) (
  input  logic            clk,
  input  logic            rst,
  mmt_in_if.sink          req,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output mmt_pkg::cmd_t   cmd
);

  logic          keep;
  mmt_pkg::cmd_t cls;
  logic          in_range;

  // A load whose indices fall outside the matrix is dropped.
  assign in_range = (32'(req.row) < 32'(DIM)) && (32'(req.col) < 32'(DIM));

  // Classify the incoming request.
  always_comb begin
    cls.row   = req.row;
    cls.col   = req.col;
    cls.value = req.value;
    cls.op    = mmt_pkg::OP_LOAD_LEFT;
    keep      = 1'b0;
    unique case (req.kind)
      mmt_pkg::KIND_LOAD_LEFT: begin
        cls.op = mmt_pkg::OP_LOAD_LEFT;
        keep   = in_range;
      end
      mmt_pkg::KIND_LOAD_RIGHT: begin
        cls.op = mmt_pkg::OP_LOAD_RIGHT;
        keep   = in_range;
      end
      mmt_pkg::KIND_MULTIPLY: begin
        cls.op = mmt_pkg::OP_MULTIPLY;
        keep   = 1'b1;
      end
      mmt_pkg::KIND_MULTIPLY_UPDATE: begin
        cls.op = mmt_pkg::OP_MULTIPLY_UPDATE;
        keep   = 1'b1;
      end
      mmt_pkg::KIND_TRANSPOSE: begin
        cls.op = mmt_pkg::OP_TRANSPOSE;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // The holding register frees up whenever the queue takes its command.
  assign req.ready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      cmd_valid <= keep;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd <= cls;
    end
  end

endmodule

// File: hw/rtl/mmt_queue.sv
// Short command queue that decouples the front end from the execution engine.
module mmt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mmt_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output mmt_pkg::cmd_t out_cmd
);

  localparam int PW = (mmt_pkg::QUEUE_DEPTH > 1) ? $clog2(mmt_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(mmt_pkg::QUEUE_DEPTH + 1);

  mmt_pkg::cmd_t  slots [mmt_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign in_ready  = (count != CW'(mmt_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(mmt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(mmt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

// File: hw/rtl/mmt_back.sv
// Execution engine: matrix storage, multiply-accumulate pipeline and result register.
module mmt_back #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  mmt_pkg::cmd_t cmd,
  mmt_out_if.source     res
);

  localparam int AW = $clog2(DIM);
  localparam int SW = 64 + $clog2(DIM);
  localparam logic [AW-1:0] LAST_IDX = AW'(DIM - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

  state_t        state;
  logic          mode_update;
  logic          mode_trans;
  logic [AW-1:0] cur_i;
  logic [AW-1:0] cur_j;
  logic          adv;

  // Pipeline stage registers.
  logic                 s1_vld, s2_vld, s3_vld;
  logic [AW-1:0]        s1_i, s1_j, s2_i, s2_j, s3_i, s3_j;
  logic                 s1_last, s2_last, s3_last;
  logic signed [31:0]   rd_l [DIM];
  logic signed [31:0]   rd_r [DIM];
  logic signed [63:0]   prod [DIM];
  logic [31:0]          tval2, tval3;
  logic signed [SW-1:0] sum3;
  logic [31:0]          rowbuf [DIM];

  // Combinational helpers.
  logic                 load_left, load_right, commit;
  logic [AW-1:0]        ld_row, ld_col, rd_la;
  logic signed [SW-1:0] acc;
  logic signed [SW-1:0] shifted;
  logic                 fits;
  logic [31:0]          res_val;
  logic                 res_sat;

  assign adv       = !res.valid || res.ready;
  assign cmd_ready = (state == ST_IDLE);
  assign ld_row    = AW'(cmd.row);
  assign ld_col    = AW'(cmd.col);
  assign load_left  = (state == ST_IDLE) && cmd_valid && (cmd.op == mmt_pkg::OP_LOAD_LEFT);
  assign load_right = (state == ST_IDLE) && cmd_valid && (cmd.op == mmt_pkg::OP_LOAD_RIGHT);
  // Transpose reads left row j; multiply reads left row i.
  assign rd_la  = mode_trans ? cur_j : cur_i;
  // A finished product row is written back to the left matrix in one go.
  assign commit = adv && s3_vld && mode_update && (s3_j == LAST_IDX);

  // Matrix storage: left lane k holds column k, right lane k holds row k.
  for (genvar k = 0; k < DIM; k++) begin : g_lane
    logic [31:0]   lmem [DIM];
    logic [31:0]   rmem [DIM];
    logic [DIM-1:0] lvld;
    logic [DIM-1:0] rvld;
    logic          l_we;
    logic [AW-1:0] l_wa;
    logic [31:0]   l_wd;
    logic          r_we;
    logic signed [31:0] l_rd;
    logic signed [31:0] r_rd;

    // Left write: a load into column k or the row write-back.
    always_comb begin
      l_we = 1'b0;
      l_wa = ld_row;
      l_wd = cmd.value;
      if (load_left && (ld_col == AW'(k))) begin
        l_we = 1'b1;
      end else if (commit) begin
        l_we = 1'b1;
        l_wa = s3_i;
        l_wd = (k == DIM - 1) ? res_val : rowbuf[k];
      end
    end

    assign r_we = load_right && (ld_row == AW'(k));

    // Written flags: an unwritten entry reads as zero.
    always_ff @(posedge clk) begin
      if (rst) begin
        lvld <= '0;
        rvld <= '0;
      end else begin
        if (l_we) begin
          lvld[l_wa] <= 1'b1;
        end
        if (r_we) begin
          rvld[ld_col] <= 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (l_we) begin
        lmem[l_wa] <= l_wd;
      end
      if (r_we) begin
        rmem[ld_col] <= cmd.value;
      end
    end

    // Registered reads for the element being issued.
    always_ff @(posedge clk) begin
      if (adv) begin
        l_rd <= lvld[rd_la] ? lmem[rd_la] : '0;
        r_rd <= rvld[cur_j] ? rmem[cur_j] : '0;
      end
    end

    assign rd_l[k] = l_rd;
    assign rd_r[k] = r_rd;
  end

  // Sequencer and valid bits of the pipeline and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      mode_update <= 1'b0;
      mode_trans  <= 1'b0;
      cur_i       <= '0;
      cur_j       <= '0;
      s1_vld      <= 1'b0;
      s2_vld      <= 1'b0;
      s3_vld      <= 1'b0;
      res.valid   <= 1'b0;
    end else begin
      if (adv) begin
        s1_vld    <= (state == ST_RUN);
        s2_vld    <= s1_vld;
        s3_vld    <= s2_vld;
        res.valid <= s3_vld;
      end
      unique case (state)
        ST_IDLE: begin
          cur_i <= '0;
          cur_j <= '0;
          if (cmd_valid) begin
            unique case (cmd.op)
              mmt_pkg::OP_MULTIPLY: begin
                mode_update <= 1'b0;
                mode_trans  <= 1'b0;
                state       <= ST_RUN;
              end
              mmt_pkg::OP_MULTIPLY_UPDATE: begin
                mode_update <= 1'b1;
                mode_trans  <= 1'b0;
                state       <= ST_RUN;
              end
              mmt_pkg::OP_TRANSPOSE: begin
                mode_update <= 1'b0;
                mode_trans  <= 1'b1;
                state       <= ST_RUN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          if (adv) begin
            if (cur_j == LAST_IDX) begin
              cur_j <= '0;
              cur_i <= cur_i + 1'b1;
              if (cur_i == LAST_IDX) begin
                state <= ST_DRAIN;
              end
            end else begin
              cur_j <= cur_j + 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (!s1_vld && !s2_vld && !s3_vld) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Sum of the lane products, exact.
  always_comb begin
    acc = '0;
    for (int k = 0; k < DIM; k++) begin
      acc = acc + SW'(prod[k]);
    end
  end

  // Scale down and clip to the signed 32-bit range; transpose passes its value through.
  always_comb begin
    shifted = sum3 >>> FRAC_BITS;
    fits    = (&shifted[SW-1:31]) || !(|shifted[SW-1:31]);
    if (mode_trans) begin
      res_val = tval3;
      res_sat = 1'b0;
    end else if (fits) begin
      res_val = shifted[31:0];
      res_sat = 1'b0;
    end else begin
      res_val = shifted[SW-1] ? mmt_pkg::Q_MIN : mmt_pkg::Q_MAX;
      res_sat = 1'b1;
    end
  end

  // Datapath stages: multiply, accumulate, result register.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_i    <= cur_i;
      s1_j    <= cur_j;
      s1_last <= (cur_i == LAST_IDX) && (cur_j == LAST_IDX);
      for (int k = 0; k < DIM; k++) begin
        prod[k] <= 64'(rd_l[k]) * 64'(rd_r[k]);
      end
      tval2   <= rd_l[s1_i];
      s2_i    <= s1_i;
      s2_j    <= s1_j;
      s2_last <= s1_last;
      sum3    <= acc;
      tval3   <= tval2;
      s3_i    <= s2_i;
      s3_j    <= s2_j;
      s3_last <= s2_last;
      res.out_row   <= 2'(s3_i);
      res.out_col   <= 2'(s3_j);
      res.out_value <= res_val;
      res.saturated <= res_sat;
      res.last      <= s3_last;
      if (s3_vld && mode_update) begin
        rowbuf[s3_j] <= res_val;
      end
    end
  end

endmodule
